[hdl/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, off while reset is low.
`define CDT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("timer check failed");

// Same check with a fixed message for handshake rules.
`define CDT_ASSERT_HS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("timer handshake check failed");

`endif

[hdl/cdt_pkg.sv]
// Types, constants and helper functions of the countdown timer.
`default_nettype none

package cdt_pkg;

    localparam int unsigned FLASH_W      = 16;
    localparam int unsigned REM_W        = 29;
    localparam int unsigned DIGIT_W      = 4;
    localparam int unsigned NUM_DIGITS   = 6;
    localparam int unsigned HOURS_W      = 7;
    localparam int unsigned MINSEC_W     = 6;
    localparam int unsigned SUBSEC_W     = 10;

    localparam logic [FLASH_W-1:0] FLASH_HALF_RESET = 16'd500;

    localparam logic [REM_W-1:0] MS_PER_HOUR   = 29'd3600000;
    localparam logic [REM_W-1:0] MS_PER_MINUTE = 29'd60000;
    localparam logic [REM_W-1:0] MS_PER_SECOND = 29'd1000;

    localparam logic [MINSEC_W-1:0] MINSEC_MAX = 6'd59;
    localparam logic [SUBSEC_W-1:0] SUBSEC_MAX = 10'd999;

    localparam logic [1:0] MODE_CODE_ENTRY   = 2'd0;
    localparam logic [1:0] MODE_CODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_CODE_PAUSED  = 2'd2;
    localparam logic [1:0] MODE_CODE_ALERT   = 2'd3;

    typedef enum logic [3:0] {
        MODE_ENTRY   = 4'b0001,
        MODE_RUNNING = 4'b0010,
        MODE_PAUSED  = 4'b0100,
        MODE_ALERT   = 4'b1000
    } t_mode;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_DIGIT  = 3'd1,
        OP_DELETE = 3'd2,
        OP_START  = 3'd3,
        OP_CANCEL = 3'd4,
        OP_PAUSE  = 3'd5
    } t_opcode;

    // Tens digit of a value up to 100 by reciprocal multiply.
    function automatic logic [DIGIT_W-1:0] cdt_tens(input logic [HOURS_W-1:0] x);
        logic [14:0] prod;
        prod = 15'(x) * 15'd205;
        return DIGIT_W'(prod >> 11);
    endfunction

    function automatic logic [DIGIT_W-1:0] cdt_ones(input logic [HOURS_W-1:0] x);
        logic [HOURS_W-1:0] tens10;
        tens10 = HOURS_W'(cdt_tens(x)) * HOURS_W'(10);
        return DIGIT_W'(x - tens10);
    endfunction

    function automatic logic [1:0] cdt_mode_code(input t_mode m);
        logic [1:0] code;
        unique case (m)
            MODE_ENTRY:   code = MODE_CODE_ENTRY;
            MODE_RUNNING: code = MODE_CODE_RUNNING;
            MODE_PAUSED:  code = MODE_CODE_PAUSED;
            MODE_ALERT:   code = MODE_CODE_ALERT;
            default:      code = MODE_CODE_ENTRY;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[hdl/countdown_timer_with_digit_entry_top.sv]
// Countdown timer with HHMMSS digit entry, top level.
//
// Input channel (i_in_valid / o_in_ready) carries one event per transfer:
// a 1 ms tick or a key (digit, delete, start, cancel, pause/resume).
// Every input transfer yields exactly one result on the output channel
// (o_out_valid / i_out_ready): mode, six display digits, flash phase and
// remaining milliseconds, all showing the state after the event.
// The result is registered: it is valid in the cycle after the input
// transfer. Throughput is one item per cycle while results are taken;
// the state update is one pass from input handshake to output register.
// The remaining time is kept both as a millisecond count and as
// hours/minutes/seconds/ms counters, so the display needs no divider.
// When the receiver stalls, the result register holds and o_in_ready
// drops until it is taken; a new input is taken in the same cycle the
// held result leaves.
// The config channel (i_cfg_valid / o_cfg_ready) writes the flash half
// period and is always ready; write it only while the block is idle.
// Synchronous active-low reset returns to entry mode, digits zero,
// remaining time zero and half period 500 ms; no result is pending.
`default_nettype none

module countdown_timer_with_digit_entry_top
    import cdt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [FLASH_W-1:0]   i_flash_half_period_ms,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [2:0]           i_opcode,
    input  wire logic [DIGIT_W-1:0]   i_digit_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_timer_mode,
    output logic [DIGIT_W-1:0]        o_hours_tens,
    output logic [DIGIT_W-1:0]        o_hours_ones,
    output logic [DIGIT_W-1:0]        o_minutes_tens,
    output logic [DIGIT_W-1:0]        o_minutes_ones,
    output logic [DIGIT_W-1:0]        o_seconds_tens,
    output logic [DIGIT_W-1:0]        o_seconds_ones,
    output logic                      o_flash_on,
    output logic [REM_W-1:0]          o_remaining_ms
);

    logic [FLASH_W-1:0]  r_half, n_half;
    t_mode               r_mode, n_mode;
    logic [DIGIT_W-1:0]  r_digit [NUM_DIGITS];
    logic [DIGIT_W-1:0]  n_digit [NUM_DIGITS];
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [HOURS_W-1:0]  r_hours, n_hours;
    logic [MINSEC_W-1:0] r_mins, n_mins;
    logic [MINSEC_W-1:0] r_secs, n_secs;
    logic [SUBSEC_W-1:0] r_subsec, n_subsec;
    logic [FLASH_W-1:0]  r_alert_cnt, n_alert_cnt;
    logic                r_phase, n_phase;
    logic                r_out_valid, n_out_valid;

    logic [1:0]          r_o_mode;
    logic [DIGIT_W-1:0]  r_o_digit [NUM_DIGITS];
    logic                r_o_flash;
    logic [REM_W-1:0]    r_o_rem;

    logic                in_xfer;
    logic [FLASH_W-1:0]  alert_next;
    logic [REM_W-1:0]    rem_dec;

    // start conversion
    logic [HOURS_W-1:0]  st_s_raw, st_m_raw, st_h;
    logic [MINSEC_W-1:0] st_s, st_m;
    logic                st_cs, st_cm;
    logic [REM_W-1:0]    st_ms;

    logic [DIGIT_W-1:0]  disp [NUM_DIGITS];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;

    assign n_half = (i_cfg_valid && o_cfg_ready) ? i_flash_half_period_ms : r_half;

    always_comb begin
        st_s_raw = HOURS_W'(r_digit[4]) * HOURS_W'(10) + HOURS_W'(r_digit[5]);
        st_cs    = st_s_raw >= HOURS_W'(60);
        st_s     = MINSEC_W'(st_cs ? st_s_raw - HOURS_W'(60) : st_s_raw);
        st_m_raw = HOURS_W'(r_digit[2]) * HOURS_W'(10) + HOURS_W'(r_digit[3])
                 + HOURS_W'(st_cs);
        st_cm    = st_m_raw >= HOURS_W'(60);
        st_m     = MINSEC_W'(st_cm ? st_m_raw - HOURS_W'(60) : st_m_raw);
        st_h     = HOURS_W'(r_digit[0]) * HOURS_W'(10) + HOURS_W'(r_digit[1])
                 + HOURS_W'(st_cm);
        st_ms    = REM_W'(st_h) * MS_PER_HOUR + REM_W'(st_m) * MS_PER_MINUTE
                 + REM_W'(st_s) * MS_PER_SECOND;
    end

    assign rem_dec    = (r_rem != '0) ? r_rem - REM_W'(1) : r_rem;
    assign alert_next = r_alert_cnt + FLASH_W'(1);

    always_comb begin
        n_mode      = r_mode;
        n_digit     = r_digit;
        n_rem       = r_rem;
        n_hours     = r_hours;
        n_mins      = r_mins;
        n_secs      = r_secs;
        n_subsec    = r_subsec;
        n_alert_cnt = r_alert_cnt;
        n_phase     = r_phase;
        if (in_xfer) begin
            if (i_opcode == OP_TICK) begin
                if (r_mode == MODE_RUNNING) begin
                    if (r_rem != '0) begin
                        n_rem = rem_dec;
                        // mixed-radix borrow chain
                        if (r_subsec != '0) begin
                            n_subsec = r_subsec - SUBSEC_W'(1);
                        end else begin
                            n_subsec = SUBSEC_MAX;
                            if (r_secs != '0) begin
                                n_secs = r_secs - MINSEC_W'(1);
                            end else begin
                                n_secs = MINSEC_MAX;
                                if (r_mins != '0) begin
                                    n_mins = r_mins - MINSEC_W'(1);
                                end else begin
                                    n_mins  = MINSEC_MAX;
                                    n_hours = r_hours - HOURS_W'(1);
                                end
                            end
                        end
                    end
                    if (rem_dec == '0) begin
                        n_mode      = MODE_ALERT;
                        n_alert_cnt = '0;
                        n_phase     = 1'b0;
                    end
                end else if (r_mode == MODE_ALERT) begin
                    if (alert_next >= r_half || alert_next == '0) begin
                        n_alert_cnt = '0;
                        n_phase     = !r_phase;
                    end else begin
                        n_alert_cnt = alert_next;
                    end
                end
            end else if (i_opcode <= OP_PAUSE) begin
                if (r_mode == MODE_ALERT) begin
                    n_mode = MODE_ENTRY;
                    for (int i = 0; i < NUM_DIGITS; i++) n_digit[i] = '0;
                end else begin
                    unique case (i_opcode)
                        OP_CANCEL: begin
                            n_mode = MODE_ENTRY;
                            for (int i = 0; i < NUM_DIGITS; i++) n_digit[i] = '0;
                        end
                        OP_PAUSE: begin
                            if (r_mode == MODE_RUNNING) begin
                                n_mode = MODE_PAUSED;
                            end else if (r_mode == MODE_PAUSED) begin
                                n_mode = MODE_RUNNING;
                            end
                        end
                        OP_DIGIT: begin
                            if (r_mode == MODE_ENTRY && i_digit_value <= DIGIT_W'(9)) begin
                                for (int i = 0; i < NUM_DIGITS - 1; i++) begin
                                    n_digit[i] = r_digit[i+1];
                                end
                                n_digit[NUM_DIGITS-1] = i_digit_value;
                            end
                        end
                        OP_DELETE: begin
                            if (r_mode == MODE_ENTRY) begin
                                for (int i = 1; i < NUM_DIGITS; i++) begin
                                    n_digit[i] = r_digit[i-1];
                                end
                                n_digit[0] = '0;
                            end
                        end
                        OP_START: begin
                            if (r_mode == MODE_ENTRY && st_ms != '0) begin
                                n_mode   = MODE_RUNNING;
                                n_rem    = st_ms;
                                n_hours  = st_h;
                                n_mins   = st_m;
                                n_secs   = st_s;
                                n_subsec = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_comb begin
        if (n_mode == MODE_ENTRY) begin
            disp = n_digit;
        end else begin
            disp[0] = cdt_tens(n_hours);
            disp[1] = cdt_ones(n_hours);
            disp[2] = cdt_tens(HOURS_W'(n_mins));
            disp[3] = cdt_ones(HOURS_W'(n_mins));
            disp[4] = cdt_tens(HOURS_W'(n_secs));
            disp[5] = cdt_ones(HOURS_W'(n_secs));
        end
    end

    assign n_out_valid = in_xfer ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= FLASH_HALF_RESET;
            r_mode      <= MODE_ENTRY;
            r_rem       <= '0;
            r_hours     <= '0;
            r_mins      <= '0;
            r_secs      <= '0;
            r_subsec    <= '0;
            r_alert_cnt <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++) r_digit[i] <= '0;
        end else begin
            r_half      <= n_half;
            r_mode      <= n_mode;
            r_rem       <= n_rem;
            r_hours     <= n_hours;
            r_mins      <= n_mins;
            r_secs      <= n_secs;
            r_subsec    <= n_subsec;
            r_alert_cnt <= n_alert_cnt;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_digit     <= n_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_o_mode  <= cdt_mode_code(n_mode);
            r_o_digit <= disp;
            r_o_flash <= (n_mode == MODE_ALERT) && !n_phase;
            r_o_rem   <= n_rem;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_timer_mode   = r_o_mode;
    assign o_hours_tens   = r_o_digit[0];
    assign o_hours_ones   = r_o_digit[1];
    assign o_minutes_tens = r_o_digit[2];
    assign o_minutes_ones = r_o_digit[3];
    assign o_seconds_tens = r_o_digit[4];
    assign o_seconds_ones = r_o_digit[5];
    assign o_flash_on     = r_o_flash;
    assign o_remaining_ms = r_o_rem;

endmodule

`default_nettype wire

[hdl/cdt_checker.sv]
// Port-level checker for the countdown timer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module cdt_checker
    import cdt_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [1:0]         o_timer_mode,
    input wire logic               o_flash_on,
    input wire logic [REM_W-1:0]   o_remaining_ms
);

    `CDT_ASSERT_HS(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_remaining_ms) && $stable(o_timer_mode))

    `CDT_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)

    `CDT_ASSERT(a_flash_only_alert, i_clk, i_rst_n, o_out_valid && o_flash_on |-> o_timer_mode == MODE_CODE_ALERT)

    `CDT_ASSERT(a_alert_at_zero, i_clk, i_rst_n, o_out_valid && o_timer_mode == MODE_CODE_ALERT |-> o_remaining_ms == '0)

    `CDT_ASSERT(a_running_nonzero, i_clk, i_rst_n, o_out_valid && (o_timer_mode == MODE_CODE_RUNNING || o_timer_mode == MODE_CODE_PAUSED) |-> o_remaining_ms != '0)

endmodule

bind countdown_timer_with_digit_entry_top cdt_checker u_cdt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_timer_mode   (o_timer_mode),
    .o_flash_on     (o_flash_on),
    .o_remaining_ms (o_remaining_ms)
);

`default_nettype wire
